/* rtl/efla_pkg.sv */
// ----------------------------------------------------------------------------
// efla_pkg: shared types and constants of the free-list allocator
// Heap geometry, request and result payloads, codes and sequencer states.
// ----------------------------------------------------------------------------
package efla_pkg;

	localparam int HEAP_BYTES = 65536;
	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int IDX_W      = $clog2(HEAP_WORDS);
	localparam int WALK_LIMIT = HEAP_BYTES / 16 + 2;
	localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
	localparam int BRK_W      = $clog2(HEAP_BYTES) + 1;
	localparam int WORD_W     = 32;
	localparam int CFG_W      = 17;

	localparam logic [WORD_W-1:0] HEAP_LIMIT  = WORD_W'(HEAP_BYTES);
	localparam logic [WORD_W-1:0] LIST_END    = 32'd8;
	localparam logic [WORD_W-1:0] MIN_BLOCK   = 32'd16;
	localparam logic [WORD_W-1:0] FIRST_BP    = 32'd16;
	localparam logic [WORD_W-1:0] SIZE_MASK   = ~32'h7;
	localparam logic [WORD_W-1:0] PROLOGUE_HD = 32'd9;
	localparam logic [WORD_W-1:0] ALLOC_BIT   = 32'd1;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ZERO   = 2'd1,
		ST_OOM    = 2'd2,
		ST_NOINIT = 2'd3
	} status_t;

	typedef enum logic {
		CFG_THRESHOLD = 1'b0,
		CFG_CHUNK     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] req_size;
		logic [15:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [15:0] result_addr;
		logic [1:0]  status;
	} rsp_t;

	// sequencer status towards the top level
	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	typedef enum logic [5:0] {
		S_IDLE, S_I0, S_I1, S_I2, S_I3,
		S_GROW, S_GW0, S_GW1, S_GW2, S_GDONE,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
		S_MA1, S_MA2, S_MB1, S_MB2, S_MC1, S_MC2, S_MC3,
		S_INS0, S_INS1, S_INS2,
		S_R0, S_R1, S_R2, S_R3,
		S_F0, S_F1, S_F2, S_FEND,
		S_PL0, S_PL1, S_PS0, S_PS1, S_PS2, S_PS3, S_PS4, S_PN0, S_PN1,
		S_FR0, S_FR1, S_FR2,
		S_DONE
	} seq_state_t;

endpackage

/* rtl/efla_if.sv */
// ----------------------------------------------------------------------------
// efla_if: request and result channels
// Valid/ready channels carrying one allocator request or one result item.
// ----------------------------------------------------------------------------
interface efla_req_if import efla_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface efla_rsp_if import efla_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* rtl/efla_seq.sv */
// ----------------------------------------------------------------------------
// efla_seq: heap sequencer
// Heap word memory with one access per cycle, driven by a sequencer that
// runs init, search, split, coalesce and list updates step by step.
// ----------------------------------------------------------------------------
module efla_seq import efla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	input  logic [CFG_W-1:0] threshold,
	input  logic [CFG_W-1:0] chunk,
	input  logic             done_ready,
	output seq_stat_t        stat,
	output rsp_t             rsp
);

	logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
	logic [WORD_W-1:0] rdata_q;

	seq_state_t state_q, state_d, mret_q, rret_q;
	req_kind_t  job_q;
	status_t    st_q;
	logic [15:0] res_q;
	logic [WORD_W-1:0] bp_q, pb_q, nb_q, sz_q, psz_q, tot_q, cs_q, asize_q;
	logic [WORD_W-1:0] best_q, bests_q, rm_q, rp_q, rn_q, gsz_q, head_q;
	logic [STEP_W-1:0] steps_q;
	logic [BRK_W-1:0]  brk_q;
	logic              ready_q, pa_q;

	logic [WORD_W-1:0] maddr, mwdata, rsz, chunk8, init_g, asize_c, remain;
	logic              mwe, use_best, na;

	// shared size and rounding terms
	assign rsz      = rdata_q & SIZE_MASK;
	assign na       = rdata_q[0];
	assign chunk8   = (WORD_W'(chunk) + 32'd7) & SIZE_MASK;
	assign init_g   = (chunk8 < MIN_BLOCK) ? MIN_BLOCK : chunk8;
	assign asize_c  = (req.req_size <= 16'd8) ? MIN_BLOCK :
		((WORD_W'(req.req_size) + 32'd15) & SIZE_MASK);
	assign use_best = asize_q > WORD_W'(threshold);
	assign remain   = cs_q - asize_q;

	// next state and heap access
	always_comb begin
		state_d = state_q;
		mwe     = 1'b0;
		maddr   = bp_q;
		mwdata  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req_kind_t'(req.req_type))
						REQ_INIT:  state_d = S_I0;
						REQ_ALLOC: state_d = (!ready_q || req.req_size == '0) ? S_DONE : S_F0;
						REQ_FREE:  state_d = (!ready_q || req.block_addr == '0) ? S_DONE : S_FR0;
						REQ_NONE:  state_d = S_DONE;
					endcase
				end
			end
			S_I0: begin
				mwe = 1'b1; maddr = 32'd0; mwdata = '0; state_d = S_I1;
			end
			S_I1: begin
				mwe = 1'b1; maddr = 32'd4; mwdata = PROLOGUE_HD; state_d = S_I2;
			end
			S_I2: begin
				mwe = 1'b1; maddr = 32'd8; mwdata = PROLOGUE_HD; state_d = S_I3;
			end
			S_I3: begin
				mwe = 1'b1; maddr = 32'd12; mwdata = ALLOC_BIT; state_d = S_GROW;
			end
			S_GROW: begin
				if (WORD_W'(brk_q) > HEAP_LIMIT || gsz_q > HEAP_LIMIT - WORD_W'(brk_q))
					state_d = S_DONE;
				else
					state_d = S_GW0;
			end
			S_GW0: begin
				mwe = 1'b1; maddr = bp_q - 32'd4; mwdata = gsz_q; state_d = S_GW1;
			end
			S_GW1: begin
				mwe = 1'b1; maddr = bp_q + gsz_q - 32'd8; mwdata = gsz_q; state_d = S_GW2;
			end
			S_GW2: begin
				mwe = 1'b1; maddr = bp_q + gsz_q - 32'd4; mwdata = ALLOC_BIT; state_d = S_M0;
			end
			S_GDONE: begin
				state_d = (job_q == REQ_INIT || bp_q == '0) ? S_DONE : S_PL0;
			end
			// coalesce: read the neighbours' tags
			S_M0: begin
				if (bp_q == FIRST_BP) begin
					maddr = bp_q - 32'd4; state_d = S_M4;
				end else begin
					maddr = bp_q - 32'd8; state_d = S_M1;
				end
			end
			S_M1: begin
				maddr = bp_q - rsz - 32'd4; state_d = S_M2;
			end
			S_M2: begin
				maddr = pb_q + rsz - 32'd8; state_d = S_M3;
			end
			S_M3: begin
				maddr = bp_q - 32'd4; state_d = S_M4;
			end
			S_M4: begin
				maddr = bp_q + rsz - 32'd4; state_d = S_M5;
			end
			S_M5: begin
				priority if (pa_q && na)  state_d = S_INS0;
				else if (pa_q)            state_d = S_R0;
				else if (na)              state_d = S_MB1;
				else                      state_d = S_MC1;
			end
			S_MA1: begin
				mwe = 1'b1; maddr = bp_q - 32'd4; mwdata = tot_q; state_d = S_MA2;
			end
			S_MA2: begin
				mwe = 1'b1; maddr = bp_q + tot_q - 32'd8; mwdata = tot_q; state_d = S_INS0;
			end
			S_MB1: begin
				mwe = 1'b1; maddr = bp_q + sz_q - 32'd8; mwdata = tot_q; state_d = S_MB2;
			end
			S_MB2: begin
				mwe = 1'b1; maddr = pb_q - 32'd4; mwdata = tot_q; state_d = S_R0;
			end
			S_MC1: begin
				mwe = 1'b1; maddr = pb_q - 32'd4; mwdata = tot_q; state_d = S_MC2;
			end
			S_MC2: begin
				mwe = 1'b1; maddr = nb_q + rn_q - 32'd8; mwdata = tot_q; state_d = S_R0;
			end
			S_MC3: state_d = S_R0;
			// push onto the free list
			S_INS0: begin
				mwe = 1'b1; maddr = head_q; mwdata = bp_q; state_d = S_INS1;
			end
			S_INS1: begin
				mwe = 1'b1; maddr = bp_q + 32'd4; mwdata = head_q; state_d = S_INS2;
			end
			S_INS2: begin
				mwe = 1'b1; maddr = bp_q; mwdata = '0; state_d = mret_q;
			end
			// unlink a block from the free list
			S_R0: begin
				maddr = rm_q; state_d = S_R1;
			end
			S_R1: begin
				maddr = rm_q + 32'd4; state_d = S_R2;
			end
			S_R2: begin
				mwe = (rp_q != '0); maddr = rp_q + 32'd4; mwdata = rdata_q; state_d = S_R3;
			end
			S_R3: begin
				mwe = 1'b1; maddr = rn_q; mwdata = rp_q; state_d = rret_q;
			end
			// free-list search
			S_F0: begin
				maddr = bp_q - 32'd4;
				if (bp_q != LIST_END && steps_q < STEP_W'(WALK_LIMIT))
					state_d = S_F1;
				else
					state_d = S_FEND;
			end
			S_F1: begin
				maddr = bp_q + 32'd4;
				state_d = (asize_q <= rsz && !use_best) ? S_PL0 : S_F2;
			end
			S_F2: state_d = S_F0;
			S_FEND: state_d = (best_q == '0) ? S_GROW : S_PL0;
			// place and split
			S_PL0: begin
				maddr = bp_q - 32'd4; state_d = S_PL1;
			end
			S_PL1: state_d = (rsz - asize_q >= MIN_BLOCK) ? S_PS0 : S_PN0;
			S_PS0: begin
				mwe = 1'b1; maddr = bp_q - 32'd4; mwdata = asize_q | ALLOC_BIT; state_d = S_PS1;
			end
			S_PS1: begin
				mwe = 1'b1; maddr = bp_q + asize_q - 32'd8; mwdata = asize_q | ALLOC_BIT;
				state_d = S_R0;
			end
			S_PS2: begin
				maddr = bp_q - 32'd4; state_d = S_PS3;
			end
			S_PS3: begin
				mwe = 1'b1; maddr = bp_q + rsz - 32'd4; mwdata = remain; state_d = S_PS4;
			end
			S_PS4: begin
				mwe = 1'b1; maddr = bp_q + (remain & SIZE_MASK) - 32'd8; mwdata = remain;
				state_d = S_M0;
			end
			S_PN0: begin
				mwe = 1'b1; maddr = bp_q - 32'd4; mwdata = cs_q | ALLOC_BIT; state_d = S_PN1;
			end
			S_PN1: begin
				mwe = 1'b1; maddr = bp_q + cs_q - 32'd8; mwdata = cs_q | ALLOC_BIT;
				state_d = S_R0;
			end
			// free: clear the tags, then coalesce
			S_FR0: begin
				maddr = bp_q - 32'd4; state_d = S_FR1;
			end
			S_FR1: begin
				mwe = 1'b1; maddr = bp_q - 32'd4; mwdata = rsz; state_d = S_FR2;
			end
			S_FR2: begin
				mwe = 1'b1; maddr = bp_q + sz_q - 32'd8; mwdata = sz_q; state_d = S_M0;
			end
			S_DONE: begin
				if (done_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// heap memory, one access per cycle
	always_ff @(posedge clk) begin
		if (mwe)
			heap_mem[maddr[IDX_W+1:2]] <= mwdata;
		else
			rdata_q <= heap_mem[maddr[IDX_W+1:2]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mret_q  <= S_DONE;
			rret_q  <= S_DONE;
			head_q  <= '0;
			brk_q   <= '0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (start && req_kind_t'(req.req_type) == REQ_INIT) begin
						brk_q   <= BRK_W'(FIRST_BP);
						head_q  <= LIST_END;
						ready_q <= 1'b1;
					end
				end
				S_GROW: begin
					mret_q <= S_GDONE;
					if (!(WORD_W'(brk_q) > HEAP_LIMIT || gsz_q > HEAP_LIMIT - WORD_W'(brk_q)))
						brk_q <= BRK_W'(WORD_W'(brk_q) + gsz_q);
				end
				S_M5:  if (pa_q && !na) rret_q <= S_MA1;
				S_MB2: rret_q <= S_INS0;
				S_MC2: rret_q <= S_MC3;
				S_MC3: rret_q <= S_INS0;
				S_INS2: head_q <= bp_q;
				S_R2:  if (rp_q == '0) head_q <= rdata_q;
				S_PS1: rret_q <= S_PS2;
				S_PS4: mret_q <= S_DONE;
				S_PN1: rret_q <= S_DONE;
				S_FR2: mret_q <= S_DONE;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					job_q <= req_kind_t'(req.req_type);
					res_q <= '0;
					st_q  <= ST_OK;
					unique case (req_kind_t'(req.req_type))
						REQ_INIT: gsz_q <= init_g;
						REQ_ALLOC: begin
							if (!ready_q)                st_q <= ST_NOINIT;
							else if (req.req_size == '0) st_q <= ST_ZERO;
							asize_q <= asize_c;
							bp_q    <= head_q;
							best_q  <= '0;
							steps_q <= '0;
						end
						REQ_FREE: begin
							if (!ready_q) st_q <= ST_NOINIT;
							bp_q <= WORD_W'(req.block_addr);
						end
						REQ_NONE: ;
					endcase
				end
			end
			S_GROW: begin
				if (WORD_W'(brk_q) > HEAP_LIMIT || gsz_q > HEAP_LIMIT - WORD_W'(brk_q))
					st_q <= ST_OOM;
				else
					bp_q <= WORD_W'(brk_q);
			end
			S_GDONE: if (bp_q == '0) st_q <= ST_OOM;
			S_M0: if (bp_q == FIRST_BP) pa_q <= 1'b1;
			S_M1: pb_q <= bp_q - rsz;
			S_M2: psz_q <= rsz;
			S_M3: pa_q <= rdata_q[0];
			S_M4: sz_q <= rsz;
			S_M5: begin
				nb_q <= bp_q + sz_q;
				rn_q <= rsz;
				priority if (pa_q && !na) begin
					tot_q <= sz_q + rsz;
					rm_q  <= bp_q + sz_q;
				end else if (!pa_q && na)
					tot_q <= sz_q + psz_q;
				else
					tot_q <= sz_q + psz_q + rsz;
			end
			S_MB2: begin
				rm_q <= pb_q;
				bp_q <= pb_q;
			end
			S_MC2: rm_q <= pb_q;
			S_MC3: begin
				rm_q <= nb_q;
				bp_q <= pb_q;
			end
			S_R1: rp_q <= rdata_q;
			S_R2: rn_q <= rdata_q;
			S_F1: begin
				if (asize_q <= rsz && use_best && (best_q == '0 || rsz < bests_q)) begin
					best_q  <= bp_q;
					bests_q <= rsz;
				end
			end
			S_F2: begin
				bp_q    <= rdata_q;
				steps_q <= steps_q + 1'b1;
			end
			S_FEND: begin
				bp_q  <= best_q;
				gsz_q <= (asize_q > chunk8) ? asize_q : chunk8;
			end
			S_PL0: res_q <= bp_q[15:0];
			S_PL1: cs_q <= rsz;
			S_PS1: rm_q <= bp_q;
			S_PS3: bp_q <= bp_q + rsz;
			S_PN1: rm_q <= bp_q;
			S_FR1: sz_q <= rsz;
			default: ;
		endcase
	end

	assign stat.idle       = (state_q == S_IDLE);
	assign stat.done       = (state_q == S_DONE);
	assign rsp.result_addr = res_q;
	assign rsp.status      = st_q;

`ifndef SYNTH
	a_brk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		WORD_W'(brk_q) <= HEAP_LIMIT)
		else $error("break beyond heap");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_F0 || state_q == S_F1 || state_q == S_F2)
		|-> steps_q <= STEP_W'(WALK_LIMIT))
		else $error("list walk past its limit");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && st_q != ST_OK) |-> res_q == '0)
		else $error("failed request carries an address");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> state_q != S_IDLE)
		else $error("accepted item not started");

	a_ready_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("heap lost its initialised state");
`endif

endmodule

/* rtl/explicit_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// explicit_free_list_allocator: boundary-tag heap allocator
// Configuration registers, request intake and the result register around
// the heap sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              accepted when
//  req      in   req_type, req_size, block_addr      req.valid && req.ready
//  rsp      out  result_addr, status                  rsp.valid && rsp.ready
//  cfg      in   cfg_idx, cfg_wdata                   cfg_we
//
//  One item at a time. Init, free and allocate each run step by step
//  on the single-port heap memory, one access per cycle; allocate walks
//  the free list block by block, then grows the heap, splits, coalesces
//  and updates the list as needed. Reset clears control state only;
//  the heap memory is not cleared and is written by init. A result waits
//  in its register while the sequencer takes the next item.
module explicit_free_list_allocator import efla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	efla_req_if.sink         req,
	efla_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0] threshold_q, chunk_q;
	logic             out_valid_q;
	rsp_t             out_q;
	seq_stat_t        stat;
	rsp_t             seq_rsp;
	logic             done_ready, start;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= CFG_W'(160);
			chunk_q     <= CFG_W'(4112);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_THRESHOLD: threshold_q <= cfg_wdata;
				CFG_CHUNK:     chunk_q     <= cfg_wdata;
			endcase
		end
	end

	assign req.ready  = stat.idle;
	assign start      = req.valid && stat.idle;
	assign done_ready = !out_valid_q || rsp.ready;

	efla_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req.payload),
		.threshold  (threshold_q),
		.chunk      (chunk_q),
		.done_ready (done_ready),
		.stat       (stat),
		.rsp        (seq_rsp)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && done_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && done_ready) out_q <= seq_rsp;
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

/* tb/tb_explicit_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// tb_explicit_free_list_allocator: self-checking bench for the heap allocator
// Drives init, allocate and free requests over several register settings,
// predicts every result with a boundary-tag heap model of its own and
// compares each result item field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_explicit_free_list_allocator;
	import efla_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RUN_LIMIT = 3000000;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned NUM_DIRECTED = 16;

	typedef struct packed {
		logic [15:0] addr;
		logic [1:0]  status;
	} alloc_res_t;

	typedef struct {
		req_t       rq;
		bit         typed;
		alloc_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	efla_req_if req();
	efla_rsp_if rsp();

	explicit_free_list_allocator u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// heap model state
	logic [31:0] heap_mem [HEAP_WORDS];
	int unsigned head_bp, brk, ready_flag, thr_reg, chunk_reg;

	alloc_res_t  pending_res [$];
	int unsigned live_blocks [$];
	int unsigned n_err, n_items, n_alloc, n_free, n_oom, n_results;
	int unsigned cycle_cnt;
	bit          calm;
	stim_row_t   directed [NUM_DIRECTED];

	// heap access, wrapping on the heap size
	function automatic int unsigned hp_rd(int unsigned a);
		return heap_mem[(a >> 2) & (HEAP_WORDS - 1)];
	endfunction

	function automatic void hp_wr(int unsigned a, int unsigned v);
		heap_mem[(a >> 2) & (HEAP_WORDS - 1)] = v;
	endfunction

	function automatic int unsigned sz_at(int unsigned a);
		return hp_rd(a) & ~32'h7;
	endfunction

	function automatic int unsigned blk_sz(int unsigned bp);
		return sz_at(bp - 4);
	endfunction

	function automatic int unsigned ftr(int unsigned bp);
		return bp + blk_sz(bp) - 8;
	endfunction

	function automatic int unsigned nxt(int unsigned bp);
		return bp + blk_sz(bp);
	endfunction

	function automatic int unsigned prv(int unsigned bp);
		return bp - sz_at(bp - 8);
	endfunction

	function automatic void unlink(int unsigned bp);
		int unsigned p, n;
		p = hp_rd(bp);
		n = hp_rd(bp + 4);
		if (p != 0) hp_wr(p + 4, n); else head_bp = n;
		hp_wr(n, p);
	endfunction

	function automatic void link_head(int unsigned bp);
		hp_wr(head_bp, bp);
		hp_wr(bp + 4, head_bp);
		hp_wr(bp, 0);
		head_bp = bp;
	endfunction

	function automatic int unsigned coalesce(int unsigned bp);
		int unsigned pa, na, sz, pb, nb, nf;
		pa = (bp == 16) ? 1 : (hp_rd(ftr(prv(bp))) & 1);
		na = hp_rd(nxt(bp) - 4) & 1;
		sz = blk_sz(bp);
		if (pa && !na) begin
			nb = nxt(bp);
			sz += blk_sz(nb);
			unlink(nb);
			hp_wr(bp - 4, sz);
			hp_wr(ftr(bp), sz);
		end else if (!pa && na) begin
			pb = prv(bp);
			sz += blk_sz(pb);
			hp_wr(ftr(bp), sz);
			hp_wr(pb - 4, sz);
			unlink(pb);
			bp = pb;
		end else if (!pa && !na) begin
			pb = prv(bp);
			nb = nxt(bp);
			nf = ftr(nb);
			sz += blk_sz(pb) + blk_sz(nb);
			hp_wr(pb - 4, sz);
			hp_wr(nf, sz);
			unlink(pb);
			unlink(nb);
			bp = pb;
		end
		link_head(bp);
		return bp;
	endfunction

	// grow the break; zero when the growth does not fit in the heap
	function automatic int unsigned extend(int unsigned sz);
		int unsigned bp;
		if (brk > HEAP_BYTES || sz > HEAP_BYTES - brk) return 0;
		bp = brk;
		brk += sz;
		hp_wr(bp - 4, sz);
		hp_wr(ftr(bp), sz);
		hp_wr(bp + sz - 4, 1);
		return coalesce(bp);
	endfunction

	function automatic int unsigned search(int unsigned asize);
		int unsigned bp, best, steps, s;
		bit use_best;
		bp = head_bp;
		best = 0;
		steps = 0;
		use_best = asize > thr_reg;
		while (bp != LIST_END && steps < WALK_LIMIT) begin
			s = blk_sz(bp);
			if (asize <= s) begin
				if (!use_best) return bp;
				if (best == 0 || s < blk_sz(best)) best = bp;
			end
			bp = hp_rd(bp + 4);
			steps++;
		end
		return best;
	endfunction

	function automatic void carve(int unsigned bp, int unsigned asize);
		int unsigned cs, rb;
		cs = blk_sz(bp);
		if (cs - asize >= 16) begin
			hp_wr(bp - 4, asize | 1);
			hp_wr(ftr(bp), asize | 1);
			unlink(bp);
			rb = nxt(bp);
			hp_wr(rb - 4, cs - asize);
			hp_wr(ftr(rb), cs - asize);
			void'(coalesce(rb));
		end else begin
			hp_wr(bp - 4, cs | 1);
			hp_wr(ftr(bp), cs | 1);
			unlink(bp);
		end
	endfunction

	function automatic int unsigned chunk_r8();
		return (chunk_reg + 7) & ~32'h7;
	endfunction

	// work out the result of one request and update the heap model
	function automatic alloc_res_t predict_alloc(req_t r);
		alloc_res_t o;
		int unsigned g, asize, bp, s;
		o.addr = '0;
		o.status = ST_OK;
		case (req_kind_t'(r.req_type))
			REQ_INIT: begin
				g = chunk_r8();
				if (g < 16) g = 16;
				brk = 16;
				hp_wr(0, 0);
				hp_wr(4, PROLOGUE_HD);
				hp_wr(8, PROLOGUE_HD);
				hp_wr(12, ALLOC_BIT);
				head_bp = LIST_END;
				ready_flag = 1;
				if (extend(g) == 0) o.status = ST_OOM;
			end
			REQ_ALLOC: begin
				if (!ready_flag) o.status = ST_NOINIT;
				else if (r.req_size == 0) o.status = ST_ZERO;
				else begin
					s = r.req_size;
					asize = (s <= 8) ? 16 : 8 * ((s + 15) / 8);
					bp = search(asize);
					if (bp == 0) begin
						g = chunk_r8();
						bp = extend(asize > g ? asize : g);
					end
					if (bp == 0) o.status = ST_OOM;
					else begin
						carve(bp, asize);
						o.addr = bp[15:0];
					end
				end
			end
			REQ_FREE: begin
				if (!ready_flag) o.status = ST_NOINIT;
				else if (r.block_addr != 0) begin
					bp = r.block_addr;
					s = blk_sz(bp);
					hp_wr(bp - 4, s);
					hp_wr(ftr(bp), s);
					void'(coalesce(bp));
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned p;
		if (calm) return 0;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(3, 1);
		if (p < 97) return $urandom_range(12, 4);
		return $urandom_range(80, 20);
	endfunction

	task automatic report_mismatch(string what);
		n_err++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// clock, cycle count and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb_explicit_free_list_allocator NOT OK");
			$finish;
		end
	end

	// result side: random stalls, check each accepted item
	int unsigned stall_left;
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			n_results++;
			if (pending_res.size() == 0) begin
				report_mismatch($sformatf("unexpected result addr %0d status %0d",
					rsp.payload.result_addr, rsp.payload.status));
			end else begin
				if (rsp.payload.result_addr !== pending_res[0].addr)
					report_mismatch($sformatf("result_addr %0d, expected %0d",
						rsp.payload.result_addr, pending_res[0].addr));
				if (rsp.payload.status !== pending_res[0].status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.payload.status, pending_res[0].status));
				void'(pending_res.pop_front());
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			stall_left <= idle_len();
			rsp.ready <= 1'b1;
		end
	end

	task automatic write_cfg(int unsigned thr, int unsigned chunk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_THRESHOLD;
		cfg_wdata <= thr[CFG_W-1:0];
		@(posedge clk);
		cfg_idx <= CFG_CHUNK;
		cfg_wdata <= chunk[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_reg = thr;
		chunk_reg = chunk;
	endtask

	// hold the item until accepted, then predict it
	task automatic send(req_t r, bit typed, alloc_res_t want);
		int unsigned gap;
		alloc_res_t got;
		gap = idle_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.payload <= r;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		n_items++;
		got = predict_alloc(r);
		if (typed && got !== want)
			report_mismatch($sformatf("model gives %0d/%0d for row, table %0d/%0d",
				got.addr, got.status, want.addr, want.status));
		pending_res.push_back(got);
		if (r.req_type == REQ_ALLOC && got.status == ST_OK) begin
			live_blocks.push_back(got.addr);
			n_alloc++;
		end
		if (got.status == ST_OOM) n_oom++;
		if (r.req_type == REQ_FREE) n_free++;
		if (r.req_type == REQ_INIT) live_blocks.delete();
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic stim_row_t mk_row(req_kind_t k, int unsigned sz, int unsigned ad,
		bit typed, int unsigned ea, status_t es);
		stim_row_t t;
		t.rq.req_type = k;
		t.rq.req_size = sz[15:0];
		t.rq.block_addr = ad[15:0];
		t.typed = typed;
		t.res.addr = ea[15:0];
		t.res.status = es;
		return t;
	endfunction

	// one random request, mostly well-formed allocate/free traffic
	task automatic send_random();
		req_t r;
		int unsigned p, k;
		p = $urandom_range(999);
		r.req_size = $urandom();
		r.block_addr = $urandom();
		if (p < 8) r.req_type = REQ_INIT;
		else if (p < 16) r.req_type = REQ_NONE;
		else if (p < 540) begin
			r.req_type = REQ_ALLOC;
			k = $urandom_range(99);
			if (k < 70) r.req_size = $urandom_range(64, 1);
			else if (k < 92) r.req_size = $urandom_range(400, 65);
			else if (k < 98) r.req_size = $urandom_range(3000, 401);
			else if (k < 99) r.req_size = 0;
		end else begin
			r.req_type = REQ_FREE;
			if (live_blocks.size() == 0 || p > 990) r.block_addr = 0;
			else begin
				k = $urandom_range(live_blocks.size() - 1);
				r.block_addr = live_blocks[k];
				live_blocks.delete(k);
			end
		end
		send(r, 1'b0, '0);
	endtask

	task automatic run_phase(int unsigned thr, int unsigned chunk, int unsigned count);
		req_t r;
		drain();
		write_cfg(thr, chunk);
		calm = ($urandom_range(3) == 0);
		r.req_type = REQ_INIT;
		r.req_size = $urandom();
		r.block_addr = $urandom();
		send(r, 1'b0, '0);
		repeat (count) send_random();
	endtask

	initial begin
		req.valid <= 1'b0;
		req.payload <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_THRESHOLD;
		cfg_wdata <= '0;
		foreach (heap_mem[i]) heap_mem[i] = '0;
		head_bp = 0;
		brk = 0;
		ready_flag = 0;
		thr_reg = 160;
		chunk_reg = 4112;
		calm = 1'b0;

		// requests before init, init, extremes and each operation
		directed[0]  = mk_row(REQ_ALLOC, 40, 0, 1, 0, ST_NOINIT);
		directed[1]  = mk_row(REQ_FREE, 0, 16, 1, 0, ST_NOINIT);
		directed[2]  = mk_row(REQ_NONE, 16'hFFFF, 16'hFFFF, 1, 0, ST_OK);
		directed[3]  = mk_row(REQ_INIT, 0, 0, 1, 0, ST_OK);
		directed[4]  = mk_row(REQ_ALLOC, 0, 0, 1, 0, ST_ZERO);
		directed[5]  = mk_row(REQ_ALLOC, 1, 0, 1, 16, ST_OK);
		directed[6]  = mk_row(REQ_ALLOC, 16'hFFFF, 0, 1, 0, ST_OOM);
		directed[7]  = mk_row(REQ_ALLOC, 8, 0, 0, 0, ST_OK);
		directed[8]  = mk_row(REQ_ALLOC, 9, 0, 0, 0, ST_OK);
		directed[9]  = mk_row(REQ_ALLOC, 500, 0, 0, 0, ST_OK);
		directed[10] = mk_row(REQ_FREE, 0, 16, 0, 0, ST_OK);
		directed[11] = mk_row(REQ_FREE, 0, 0, 1, 0, ST_OK);
		directed[12] = mk_row(REQ_ALLOC, 5000, 0, 0, 0, ST_OK);
		directed[13] = mk_row(REQ_ALLOC, 2, 0, 0, 0, ST_OK);
		directed[14] = mk_row(REQ_NONE, 0, 0, 1, 0, ST_OK);
		directed[15] = mk_row(REQ_INIT, 16'hFFFF, 16'hFFFF, 0, 0, ST_OK);

		@(posedge arst_n);
		@(posedge clk);
		foreach (directed[i]) send(directed[i].rq, directed[i].typed, directed[i].res);
		repeat (250) send_random();

		// settings from the extremes to random ones
		run_phase(0, 8, 220);
		run_phase(65536, 65536, 20);
		run_phase(65536, 16, 220);
		run_phase(0, 65536, 40);
		repeat (3) run_phase($urandom_range(400), $urandom_range(1200, 8), 250);

		drain();
		$display("%0d requests: %0d allocations, %0d frees, %0d out of memory",
			n_items, n_alloc, n_free, n_oom);
		$display("%0d result items checked over 8 register settings", n_results);
		if (n_err == 0) begin
			$display("tb_explicit_free_list_allocator OK");
		end else begin
			$display("tb_explicit_free_list_allocator NOT OK");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/efla_pkg.sv
rtl/efla_if.sv
rtl/efla_seq.sv
rtl/explicit_free_list_allocator.sv
tb/tb_explicit_free_list_allocator.sv
